/* rtl/core/lrup_pkg.sv */
// Shared widths, constants and cell command type for the LRU page replacement block.
package lrup_pkg;

	localparam int unsigned PAGE_W  = 6;
	localparam int unsigned FRAME_W = 7;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned IN_W    = 8;
	localparam int unsigned OUT_W   = 48;

	localparam logic [FRAME_W-1:0] FRAME_RESET = 7'd4;

	// Output bus layout, lowest bit up
	localparam int unsigned O_HIT  = 0;
	localparam int unsigned O_EVV  = 1;
	localparam int unsigned O_EVP  = 2;
	localparam int unsigned O_CNT  = O_EVP + PAGE_W;
	localparam int unsigned O_TEX  = O_CNT + COUNT_W;

	// Broadcast command from the controller to every cell
	typedef struct packed {
		logic stamp;
		logic set;
		logic clr;
	} cell_cmd_t;

endpackage

/* rtl/core/lrup_cell.sv */
// One page cell: resident bit, last-use stamp and one stage of the oldest-page scan.
module lrup_cell #(
	parameter int unsigned INDEX      = 0,
	parameter int unsigned NUM_PAGES  = 64,
	parameter int unsigned TIME_WIDTH = 32,
	localparam int unsigned PW        = $clog2(NUM_PAGES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lrup_pkg::cell_cmd_t   cmd,
	input  logic [PW-1:0]         page_idx,
	input  logic [PW-1:0]         victim_idx,
	input  logic [TIME_WIDTH-1:0] tick,
	input  logic                  tok_in_v,
	input  logic                  tok_in_found,
	input  logic [TIME_WIDTH-1:0] tok_in_oldest,
	input  logic [PW-1:0]         tok_in_victim,
	output logic                  tok_out_v,
	output logic                  tok_out_found,
	output logic [TIME_WIDTH-1:0] tok_out_oldest,
	output logic [PW-1:0]         tok_out_victim,
	output logic                  resident
);

	localparam logic [PW-1:0] MY_IDX = PW'(INDEX);

	logic                  resident_q;
	logic [TIME_WIDTH-1:0] stamp_q;
	logic                  tok_v_q;
	logic                  tok_found_q;
	logic [TIME_WIDTH-1:0] tok_oldest_q;
	logic [PW-1:0]         tok_victim_q;
	logic                  take;

	// Claim the scan token when this page is resident and strictly older
	assign take = resident_q && (!tok_in_found || (stamp_q < tok_in_oldest));

	// Track residency: clear on eviction, set on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resident_q <= 1'b0;
			tok_v_q    <= 1'b0;
		end else begin
			tok_v_q <= tok_in_v;
			if (cmd.clr && (victim_idx == MY_IDX))
				resident_q <= 1'b0;
			if (cmd.set && (page_idx == MY_IDX))
				resident_q <= 1'b1;
		end
	end

	// Stamp on reference; pass the scan token on to the next cell
	always_ff @(posedge clk) begin
		if (cmd.stamp && (page_idx == MY_IDX))
			stamp_q <= tick;
		tok_found_q  <= tok_in_found | take;
		tok_oldest_q <= take ? stamp_q : tok_in_oldest;
		tok_victim_q <= take ? MY_IDX : tok_in_victim;
	end

	assign tok_out_v      = tok_v_q;
	assign tok_out_found  = tok_found_q;
	assign tok_out_oldest = tok_oldest_q;
	assign tok_out_victim = tok_victim_q;
	assign resident       = resident_q;

endmodule

/* rtl/core/lru_page_replacement.sv */
// Top level of the LRU page replacement block: controller, cell chain and result register.
// One page reference per request. A hit, an out-of-range page or a miss that finds a free
// frame gives its result in the cycle after acceptance. A miss with all frames in use sends
// a scan token down the chain of NUM_PAGES page cells, one cell per cycle, to find the
// resident page with the oldest stamp (lowest index on a tie); its result is registered
// once the token leaves the last cell. One reference is worked on at a time, and a new
// one is taken once the result register is free or being drained. frame_count 0 acts as 1.
module lru_page_replacement #(
	parameter int unsigned NUM_PAGES  = 64,
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lrup_pkg::IN_W-1:0]         s_tdata,   // [5:0] page_number
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] hit, [1] evicted_valid, [7:2] evicted_page, [39:8] eviction_count,
	// [40] time_exhausted
	output logic [lrup_pkg::OUT_W-1:0]        m_tdata,
	input  logic                              cfg_we,
	input  logic [lrup_pkg::FRAME_W-1:0]      cfg_wdata
);

	localparam int unsigned PW = $clog2(NUM_PAGES);
	localparam int unsigned IW = (PW > lrup_pkg::PAGE_W) ? PW : lrup_pkg::PAGE_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                             state_q;
	logic [lrup_pkg::FRAME_W-1:0]     frame_count_q;
	logic [lrup_pkg::FRAME_W-1:0]     frames_used_q;
	logic [TIME_WIDTH-1:0]            tick_q;
	logic                             overflowed_q;
	logic [lrup_pkg::COUNT_W-1:0]     repl_q;
	logic [PW-1:0]                    page_q;

	logic                             out_v_q;
	logic                             out_hit_q;
	logic                             out_evv_q;
	logic [lrup_pkg::PAGE_W-1:0]      out_evp_q;
	logic [lrup_pkg::COUNT_W-1:0]     out_cnt_q;
	logic                             out_tex_q;

	logic [IW-1:0]                    page_w;
	logic                             in_range;
	logic [PW-1:0]                    idx;
	logic [NUM_PAGES-1:0]             res_vec;
	logic                             is_res;
	logic [lrup_pkg::FRAME_W-1:0]     limit;
	logic                             full;
	logic                             accept;
	logic                             need_scan;
	logic                             direct;
	logic                             finish;
	logic                             found;
	logic [PW-1:0]                    victim;
	logic                             tick_max;
	logic                             ovf_next;
	logic [lrup_pkg::COUNT_W-1:0]     repl_next;
	logic [lrup_pkg::FRAME_W-1:0]     fu_dec;
	lrup_pkg::cell_cmd_t              cmd;
	logic [PW-1:0]                    bus_page;

	logic                  tok_v      [NUM_PAGES+1];
	logic                  tok_found  [NUM_PAGES+1];
	logic [TIME_WIDTH-1:0] tok_oldest [NUM_PAGES+1];
	logic [PW-1:0]         tok_victim [NUM_PAGES+1];

	// Decode the request
	assign page_w    = IW'(s_tdata[lrup_pkg::PAGE_W-1:0]);
	assign in_range  = {1'b0, page_w} < (IW+1)'(NUM_PAGES);
	assign idx       = page_w[PW-1:0];
	assign is_res    = res_vec[idx];
	assign limit     = (frame_count_q == '0) ? lrup_pkg::FRAME_W'(1) : frame_count_q;
	assign full      = frames_used_q >= limit;
	assign s_tready  = (state_q == ST_IDLE) && (!out_v_q || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign need_scan = in_range && !is_res && full;
	assign direct    = accept && !need_scan;
	assign tick_max  = &tick_q;
	assign ovf_next  = overflowed_q | (in_range & tick_max);

	// Scan result at the end of the chain
	assign finish    = (state_q == ST_SCAN) && tok_v[NUM_PAGES];
	assign found     = tok_found[NUM_PAGES];
	assign victim    = tok_victim[NUM_PAGES];
	assign repl_next = (found && (repl_q != '1)) ? repl_q + 1'b1 : repl_q;
	assign fu_dec    = (found && (frames_used_q != '0)) ? frames_used_q - 1'b1 : frames_used_q;

	// Broadcast commands to the cells
	assign bus_page  = (state_q == ST_IDLE) ? idx : page_q;
	assign cmd.stamp = accept && in_range;
	assign cmd.set   = (accept && in_range && !is_res && !full) || finish;
	assign cmd.clr   = finish && found;

	// Inject the scan token at the head of the chain
	assign tok_v[0]      = accept && need_scan;
	assign tok_found[0]  = 1'b0;
	assign tok_oldest[0] = '0;
	assign tok_victim[0] = '0;

	for (genvar g = 0; g < NUM_PAGES; g++) begin : g_cell
		lrup_cell #(
			.INDEX      (g),
			.NUM_PAGES  (NUM_PAGES),
			.TIME_WIDTH (TIME_WIDTH)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.cmd            (cmd),
			.page_idx       (bus_page),
			.victim_idx     (victim),
			.tick           (tick_q),
			.tok_in_v       (tok_v[g]),
			.tok_in_found   (tok_found[g]),
			.tok_in_oldest  (tok_oldest[g]),
			.tok_in_victim  (tok_victim[g]),
			.tok_out_v      (tok_v[g+1]),
			.tok_out_found  (tok_found[g+1]),
			.tok_out_oldest (tok_oldest[g+1]),
			.tok_out_victim (tok_victim[g+1]),
			.resident       (res_vec[g])
		);
	end

	// Control state: sequencer, counters, tick and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			frame_count_q <= lrup_pkg::FRAME_RESET;
			frames_used_q <= '0;
			tick_q        <= '0;
			overflowed_q  <= 1'b0;
			repl_q        <= '0;
			out_v_q       <= 1'b0;
		end else begin
			if (cfg_we)
				frame_count_q <= cfg_wdata;

			if (accept && in_range) begin
				if (tick_max)
					overflowed_q <= 1'b1;
				else
					tick_q <= tick_q + 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && need_scan)
						state_q <= ST_SCAN;
					if (accept && in_range && !is_res && !full)
						frames_used_q <= frames_used_q + 1'b1;
				end
				ST_SCAN: begin
					if (finish) begin
						state_q       <= ST_IDLE;
						frames_used_q <= fu_dec + 1'b1;
						repl_q        <= repl_next;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (direct || finish)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
		end
	end

	// Hold the page under scan and load the result register
	always_ff @(posedge clk) begin
		if (accept)
			page_q <= idx;
		if (direct) begin
			out_hit_q <= in_range && is_res;
			out_evv_q <= 1'b0;
			out_evp_q <= '0;
			out_cnt_q <= repl_q;
			out_tex_q <= ovf_next;
		end else if (finish) begin
			out_hit_q <= 1'b0;
			out_evv_q <= found;
			out_evp_q <= found ? lrup_pkg::PAGE_W'(victim) : '0;
			out_cnt_q <= repl_next;
			out_tex_q <= overflowed_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {
		(lrup_pkg::OUT_W - lrup_pkg::O_TEX - 1)'(0),
		out_tex_q, out_cnt_q, out_evp_q, out_evv_q, out_hit_q
	};

endmodule

/* rtl/core/lrup_checker.sv */
// Port-level checks for the LRU page replacement block, bound to the top level.
module lrup_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lrup_pkg::OUT_W-1:0]    m_tdata
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// No new request taken while a result is stalled
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request taken while result stalled");

	// A hit never evicts
	a_hit_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[lrup_pkg::O_HIT] && m_tdata[lrup_pkg::O_EVV]))
		else $error("hit with eviction");

	// Evicted page reads zero when nothing was evicted
	a_evp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[lrup_pkg::O_EVV]
		|-> m_tdata[lrup_pkg::O_CNT-1:lrup_pkg::O_EVP] == '0)
		else $error("evicted page set without eviction");

endmodule

bind lru_page_replacement lrup_checker u_lrup_checker (.*);
